[sv/ae2f_pkg.sv]
// ----------------------------------------------------------------------------
// ae2f_pkg
// Shared types, codes and constants of the array element converter.
// ----------------------------------------------------------------------------
package ae2f_pkg;

   localparam logic [2:0] KIND_BOOL    = 3'd0;
   localparam logic [2:0] KIND_UINT    = 3'd1;
   localparam logic [2:0] KIND_SINT    = 3'd2;
   localparam logic [2:0] KIND_FLOAT   = 3'd3;
   localparam logic [2:0] KIND_COMPLEX = 3'd4;

   localparam logic [1:0] REG_KIND   = 2'd0;
   localparam logic [1:0] REG_SIZE   = 2'd1;
   localparam logic [1:0] REG_LITTLE = 2'd2;

   localparam logic [2:0] RESET_KIND   = KIND_FLOAT;
   localparam logic [4:0] RESET_SIZE   = 5'd8;
   localparam logic       RESET_LITTLE = 1'b1;

   localparam int DATA_W = 64;

   // decoded operation carried down the pipeline
   typedef struct packed {
      logic       ok;
      logic       is_bool;
      logic       is_int;
      logic       is_float;
      logic       is_cplx;
      logic [1:0] fsize;     // 0 half, 1 single, 2 double
   } op_type;

   localparam logic [1:0] FSZ_HALF   = 2'd0;
   localparam logic [1:0] FSZ_SINGLE = 2'd1;
   localparam logic [1:0] FSZ_DOUBLE = 2'd2;

   // leading one position of a 64 bit word (0 when zero)
   function automatic logic [5:0] top_bit64(input logic [63:0] x);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

   // single to double widening, subnormals normalized, NaN quieted
   function automatic logic [63:0] f32_to_f64(input logic [31:0] x);
      logic        s;
      logic [7:0]  e;
      logic [22:0] f;
      logic [5:0]  p;
      logic [51:0] m;
      logic [63:0] r;
      s = x[31];
      e = x[30:23];
      f = x[22:0];
      p = top_bit64({41'd0, f});
      m = 52'({29'd0, f} << (6'd52 - p));
      if (e == 8'd0) begin
         if (f == 23'd0) r = {s, 63'd0};
         else r = {s, 11'(p + 11'd874), m};
      end else if (e == 8'hff) begin
         if (f == 23'd0) r = {s, 11'h7ff, 52'd0};
         else r = {s, 11'h7ff, 1'b1, f[21:0], 29'd0};
      end else begin
         r = {s, 11'({3'd0, e} + 11'd896), f, 29'd0};
      end
      return r;
   endfunction

   // half to single widening
   function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
      logic        s;
      logic [4:0]  e;
      logic [9:0]  f;
      logic [5:0]  p;
      logic [9:0]  fn;
      logic [31:0] r;
      s = h[15];
      e = h[14:10];
      f = h[9:0];
      p = top_bit64({54'd0, f});
      fn = 10'({1'b0, f} << (6'd10 - p));
      if (e == 5'd0 && f != 10'd0) begin
         r = {s, 8'(8'd103 + {2'd0, p}), fn, 13'd0};
      end else if (e == 5'd0) begin
         r = {s, 31'd0};
      end else if (e == 5'd31) begin
         r = {s, 8'hff, f, 13'd0};
      end else begin
         r = {s, 8'({3'd0, e} + 8'd112), f, 13'd0};
      end
      return r;
   endfunction

endpackage

[sv/ae2f_unpack.sv]
// ----------------------------------------------------------------------------
// ae2f_unpack
// Stage 1: format decode, byte gather and integer sign/magnitude split.
// ----------------------------------------------------------------------------
module ae2f_unpack (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [2:0]            kind,
   input  logic [4:0]            size,
   input  logic                  little,
   input  logic [63:0]           b_first,
   input  logic [63:0]           b_second,
   output logic                  out_valid,
   output ae2f_pkg::op_type      out_op,
   output logic [63:0]           out_a,     // raw / magnitude / real component
   output logic [63:0]           out_b,     // imag component
   output logic                  out_neg
);

   logic              valid_ff;
   ae2f_pkg::op_type  op_ff, op_in;
   logic [63:0]       a_ff, a_in, b_ff, b_in;
   logic              neg_ff, neg_in;
   logic [127:0]      all_b;
   logic [63:0]       raw, mask, mag;
   logic [3:0]        n;
   logic [3:0]        c;

   function automatic logic [63:0] gather(input logic [127:0] b, input logic [3:0] off,
                                          input logic [3:0] cnt, input logic le);
      logic [63:0] v;
      logic [3:0]  sh;
      v = 64'd0;
      for (int i = 0; i < 8; i++) begin
         sh = le ? 4'(i) : 4'(cnt - 4'd1 - 4'(i));
         if (4'(i) < cnt) begin
            v[8*sh[2:0] +: 8] = b[8*(4'(off + 4'(i))) +: 8];
         end
      end
      return v;
   endfunction

   always_comb begin
      op_in = '0;
      unique case (kind) inside
         ae2f_pkg::KIND_BOOL: op_in.ok = (size == 5'd1);
         ae2f_pkg::KIND_UINT, ae2f_pkg::KIND_SINT:
            op_in.ok = (size == 5'd1 || size == 5'd2 || size == 5'd4 || size == 5'd8);
         ae2f_pkg::KIND_FLOAT: op_in.ok = (size == 5'd2 || size == 5'd4 || size == 5'd8);
         ae2f_pkg::KIND_COMPLEX: op_in.ok = (size == 5'd8 || size == 5'd16);
         default: op_in.ok = 1'b0;
      endcase
      op_in.is_bool  = (kind == ae2f_pkg::KIND_BOOL);
      op_in.is_int   = (kind == ae2f_pkg::KIND_UINT || kind == ae2f_pkg::KIND_SINT);
      op_in.is_float = (kind == ae2f_pkg::KIND_FLOAT);
      op_in.is_cplx  = (kind == ae2f_pkg::KIND_COMPLEX);
      if (op_in.is_cplx) begin
         op_in.fsize = (size == 5'd8) ? ae2f_pkg::FSZ_SINGLE : ae2f_pkg::FSZ_DOUBLE;
      end else begin
         op_in.fsize = (size == 5'd2) ? ae2f_pkg::FSZ_HALF :
                       (size == 5'd4) ? ae2f_pkg::FSZ_SINGLE : ae2f_pkg::FSZ_DOUBLE;
      end
      all_b = {b_second, b_first};
      n = size[3:0];
      c = size[4:1];
      raw = gather(all_b, 4'd0, n, little);
      mask = (size == 5'd8) ? '1 : ((64'd1 << {n, 3'd0}) - 64'd1);
      mag = ((~raw) & mask) + 64'd1;
      neg_in = 1'b0;
      a_in = raw;
      b_in = 64'd0;
      if (op_in.is_cplx) begin
         a_in = gather(all_b, 4'd0, c, little);
         b_in = gather(all_b, c, c, little);
      end else if (kind == ae2f_pkg::KIND_SINT && raw[6'({n, 3'd0} - 7'd1)]) begin
         neg_in = 1'b1;
         a_in = mag;
      end
      if (!op_in.ok) begin
         a_in = 64'd0;
         b_in = 64'd0;
         neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         op_ff  <= op_in;
         a_ff   <= a_in;
         b_ff   <= b_in;
         neg_ff <= neg_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_op    = op_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_neg   = neg_ff;

endmodule

[sv/ae2f_norm.sv]
// ----------------------------------------------------------------------------
// ae2f_norm
// Stage 2: leading one search and alignment of integers, float widening.
// ----------------------------------------------------------------------------
module ae2f_norm (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  ae2f_pkg::op_type  in_op,
   input  logic [63:0]       in_a,
   input  logic [63:0]       in_b,
   input  logic              in_neg,
   output logic              out_valid,
   output ae2f_pkg::op_type  out_op,
   output logic [63:0]       out_a,     // float result, or aligned integer bits
   output logic [63:0]       out_b,
   output logic              out_neg,
   output logic [5:0]        out_p,
   output logic              out_zero
);

   logic              valid_ff;
   ae2f_pkg::op_type  op_ff;
   logic [63:0]       a_ff, a_in, b_ff, b_in;
   logic              neg_ff, zero_ff, zero_in;
   logic [5:0]        p_ff, p_in;

   function automatic logic [63:0] fwiden(input logic [63:0] raw, input logic [1:0] fs);
      logic [63:0] r;
      case (fs)
         ae2f_pkg::FSZ_HALF:   r = ae2f_pkg::f32_to_f64(ae2f_pkg::f16_to_f32(raw[15:0]));
         ae2f_pkg::FSZ_SINGLE: r = ae2f_pkg::f32_to_f64(raw[31:0]);
         default:              r = raw;
      endcase
      return r;
   endfunction

   always_comb begin
      p_in = ae2f_pkg::top_bit64(in_a);
      zero_in = (in_a == 64'd0);
      a_in = in_a;
      b_in = 64'd0;
      if (in_op.is_float || in_op.is_cplx) begin
         a_in = in_op.ok ? fwiden(in_a, in_op.fsize) : 64'd0;
         b_in = (in_op.ok && in_op.is_cplx) ? fwiden(in_b, in_op.fsize) : 64'd0;
      end else if (in_op.is_int) begin
         // left align so the leading one sits at bit 63
         a_in = in_a << (6'd63 - p_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         op_ff   <= in_op;
         a_ff    <= a_in;
         b_ff    <= b_in;
         neg_ff  <= in_neg;
         p_ff    <= p_in;
         zero_ff <= zero_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_op    = op_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_neg   = neg_ff;
   assign out_p     = p_ff;
   assign out_zero  = zero_ff;

endmodule

[sv/ae2f_pack.sv]
// ----------------------------------------------------------------------------
// ae2f_pack
// Stage 3: integer rounding to nearest even and result assembly.
// ----------------------------------------------------------------------------
module ae2f_pack (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  ae2f_pkg::op_type  in_op,
   input  logic [63:0]       in_a,
   input  logic [63:0]       in_b,
   input  logic              in_neg,
   input  logic [5:0]        in_p,
   input  logic              in_zero,
   output logic              out_valid,
   output logic [63:0]       out_re,
   output logic [63:0]       out_im,
   output logic              out_bad
);

   logic        valid_ff, bad_ff;
   logic [63:0] re_ff, re_in, im_ff;
   logic [52:0] mant;
   logic        g, st, up;
   logic [63:0] ival;

   always_comb begin
      // in_a: leading one at bit 63, 52 fraction bits below, then guard, sticky
      g    = in_a[10];
      st   = |in_a[9:0];
      up   = g & (st | in_a[11]);
      // mant[52] is the carry out of the fraction
      mant = {1'b0, in_a[62:11]} + {52'd0, up};
      ival = {in_neg, 63'd0} + ({53'd0, 11'(11'd1023 + {5'd0, in_p})} << 52)
             + {12'd0, mant[51:0]} + ({63'd0, mant[52]} << 52);
      if (!in_op.ok) begin
         re_in = 64'd0;
      end else if (in_op.is_bool) begin
         re_in = in_zero ? 64'd0 : {2'b00, 10'h3ff, 52'd0};
      end else if (in_op.is_int) begin
         re_in = in_zero ? 64'd0 : ival;
      end else begin
         re_in = in_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         re_ff  <= re_in;
         im_ff  <= in_b;
         bad_ff <= !in_op.ok;
      end
   end

   assign out_valid = valid_ff;
   assign out_re    = re_ff;
   assign out_im    = im_ff;
   assign out_bad   = bad_ff;

endmodule

[sv/array_element_to_float64.sv]
// ----------------------------------------------------------------------------
// array_element_to_float64
// Converts one raw array element (bool, integer, half/single/double float or
// complex) into binary64 bit patterns. Three register stages (unpack,
// normalize, round/pack) take one request per cycle while the result side
// is not stalled; a stall on the result side holds all stages. The user must write the configuration
// through the csr port while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module array_element_to_float64 (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // bytes_first[63:0], bytes_second[127:64]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,   // real_bits[63:0], imag_bits[127:64], bad_format[128]
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [4:0]    csr_data
);

   logic [2:0]        kind_ff;
   logic [4:0]        size_ff;
   logic              little_ff;
   logic              adv;
   logic              v1, v2, v3;
   ae2f_pkg::op_type  op1, op2;
   logic [63:0]       a1, b1, a2, b2, re3, im3;
   logic              n1, n2, z2, bad3;
   logic [5:0]        p2;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= ae2f_pkg::RESET_KIND;
         size_ff   <= ae2f_pkg::RESET_SIZE;
         little_ff <= ae2f_pkg::RESET_LITTLE;
      end else if (csr_valid) begin
         unique case (csr_index)
            ae2f_pkg::REG_KIND:   kind_ff   <= csr_data[2:0];
            ae2f_pkg::REG_SIZE:   size_ff   <= csr_data;
            ae2f_pkg::REG_LITTLE: little_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   ae2f_unpack u_unpack (
      .clock, .reset, .adv,
      .in_valid (req_tvalid),
      .kind     (kind_ff),
      .size     (size_ff),
      .little   (little_ff),
      .b_first  (req_tdata[63:0]),
      .b_second (req_tdata[127:64]),
      .out_valid(v1), .out_op(op1), .out_a(a1), .out_b(b1), .out_neg(n1)
   );

   ae2f_norm u_norm (
      .clock, .reset, .adv,
      .in_valid(v1), .in_op(op1), .in_a(a1), .in_b(b1), .in_neg(n1),
      .out_valid(v2), .out_op(op2), .out_a(a2), .out_b(b2), .out_neg(n2),
      .out_p(p2), .out_zero(z2)
   );

   ae2f_pack u_pack (
      .clock, .reset, .adv,
      .in_valid(v2), .in_op(op2), .in_a(a2), .in_b(b2), .in_neg(n2),
      .in_p(p2), .in_zero(z2),
      .out_valid(v3), .out_re(re3), .out_im(im3), .out_bad(bad3)
   );

   assign rsp_tvalid = v3;
   assign rsp_tdata  = {7'd0, bad3, im3, re3};

endmodule

[sv/ae2f_checker.sv]
// ----------------------------------------------------------------------------
// ae2f_props
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module ae2f_props (
   input logic          clock,
   input logic          reset,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [135:0]  rsp_tdata
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty output");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[128] |-> rsp_tdata[127:0] == 128'd0)
      else $error("bad format with nonzero data");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[135:129] == 7'd0)
      else $error("padding not zero");

endmodule

bind array_element_to_float64 ae2f_props u_ae2f_props (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
